[rtl/wsfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared result codes and the result record passed from parser to queue.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_INCOMPL  = 3'd3,
    ST_TRUNC    = 3'd4,
    ST_CLOSE    = 3'd5
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [3:0]  opcode;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        last;
  } result_t;

  localparam logic [7:0] MaskBit   = 8'h80;
  localparam logic [6:0] LenMask   = 7'h7f;
  localparam logic [6:0] LenExt16  = 7'd126;
  localparam logic [6:0] LenExt64  = 7'd127;
  localparam logic [7:0] OpMask    = 8'h0f;
  localparam int         KeyBytes  = 4;

endpackage

[rtl/wsfp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser front end
// Header state machine: takes one stream byte per cycle while take_i is high,
// unmasks payload bytes, yields at most one result record per accepted request.
// ----------------------------------------------------------------------------
module wsfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output logic              res_valid_o,
  output wsfp_pkg::result_t res_o
);
  import wsfp_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_HDR2    = 7'b0000010,
    PH_EXT_HI  = 7'b0000100,
    PH_EXT_LO  = 7'b0001000,
    PH_KEY     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DRAIN   = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_on_q, mask_on_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  len_high_q, len_high_d;
  logic [7:0]  key_q [KeyBytes];
  logic        key_we;
  logic [15:0] count_inc;
  logic [7:0]  plain_byte;
  logic [6:0]  len_code;
  logic [15:0] hdr_len;

  assign count_inc  = count_q + 16'd1;
  assign len_code   = data_byte_i[6:0] & LenMask;
  assign plain_byte = mask_on_q ? (data_byte_i ^ key_q[count_q[1:0]]) : data_byte_i;
  assign key_we     = take_i && !end_of_stream_i && (phase_q == PH_KEY);

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    mask_on_d   = mask_on_q;
    len_d       = len_q;
    count_d     = count_q;
    len_high_d  = len_high_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_DATA, opcode: opcode_q, payload_byte: 8'd0,
                    frame_length: 16'd0, last: 1'b0};
    hdr_len     = {8'd0, 1'b0, len_code};

    if (take_i) begin
      if (end_of_stream_i) begin
        phase_d     = PH_IDLE;
        res_valid_o = 1'b1;
        unique case (phase_q)
          PH_HDR2: begin
            res_o.status = ST_INCOMPL;
          end
          PH_EXT_HI, PH_EXT_LO, PH_KEY, PH_PAYLOAD: begin
            res_o.status       = ST_TRUNC;
            res_o.frame_length = len_q;
          end
          PH_DRAIN: begin
            res_valid_o = 1'b0;
          end
          default: begin
            res_o.status = ST_CLOSE;
            res_o.opcode = 4'd0;
          end
        endcase
      end else begin
        unique case (phase_q)
          PH_HDR2: begin
            mask_on_d = (data_byte_i & MaskBit) != 8'd0;
            if (len_code == LenExt16) begin
              phase_d = PH_EXT_HI;
            end else if (len_code == LenExt64) begin
              phase_d      = PH_DRAIN;
              res_valid_o  = 1'b1;
              res_o.status = ST_TOO_LONG;
            end else begin
              len_d   = hdr_len;
              count_d = 16'd0;
              if (mask_on_d) begin
                phase_d = PH_KEY;
              end else if (hdr_len == 16'd0) begin
                phase_d      = PH_IDLE;
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
                res_o.last   = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_EXT_HI: begin
            len_high_d = data_byte_i;
            phase_d    = PH_EXT_LO;
          end
          PH_EXT_LO: begin
            len_d   = {len_high_q, data_byte_i};
            count_d = 16'd0;
            if (mask_on_q) begin
              phase_d = PH_KEY;
            end else if (len_d == 16'd0) begin
              phase_d      = PH_IDLE;
              res_valid_o  = 1'b1;
              res_o.status = ST_EMPTY;
              res_o.last   = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
          PH_KEY: begin
            count_d = count_inc;
            if (count_inc >= 16'(KeyBytes)) begin
              count_d = 16'd0;
              if (len_q == 16'd0) begin
                phase_d      = PH_IDLE;
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
                res_o.last   = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            count_d            = count_inc;
            res_valid_o        = 1'b1;
            res_o.payload_byte = plain_byte;
            res_o.frame_length = len_q;
            res_o.last         = count_inc >= len_q;
            if (res_o.last) begin
              phase_d = PH_IDLE;
            end
          end
          PH_DRAIN: begin
            phase_d = PH_DRAIN;
          end
          default: begin
            // Idle, and any unused code: this byte opens a new frame.
            opcode_d   = 4'(data_byte_i & OpMask);
            mask_on_d  = 1'b0;
            len_d      = 16'd0;
            count_d    = 16'd0;
            len_high_d = 8'd0;
            phase_d    = PH_HDR2;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      opcode_q   <= 4'd0;
      mask_on_q  <= 1'b0;
      len_q      <= 16'd0;
      count_q    <= 16'd0;
      len_high_q <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      mask_on_q  <= mask_on_d;
      len_q      <= len_d;
      count_q    <= count_d;
      len_high_q <= len_high_d;
    end
  end

  // The masking key is always fully written before a payload byte reads it.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[count_q[1:0]] <= data_byte_i;
    end
  end

endmodule

[rtl/wsfp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser result queue
// Small FIFO of result records; its head drives the result ports.
// ----------------------------------------------------------------------------
module wsfp_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  wsfp_pkg::result_t wdata_i,
  input  logic              rd_i,
  output wsfp_pkg::result_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import wsfp_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  result_t          mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + AddrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + AddrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/websocket_frame_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser top level
// Parses a received byte stream into unmasked payload bytes and status events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive data_byte_i / end_of_stream_i and raise push; the
//   request is taken at a clock edge with push high and full low. With
//   end_of_stream_i high the byte is ignored and the stream is closed.
//   Result channel: while empty is low the oldest result sits on status_o,
//   opcode_o, payload_byte_o, frame_length_o and last_o; pop takes it.
//   Each request gives zero or one result. A result is written into the queue
//   at the edge that takes its request, so empty falls at that same edge and
//   the result can then be popped.
//   Throughput is one byte per cycle while full is low; the header state
//   machine is registered, and results pass through a Depth-entry queue.
//   If the receiver stops popping, the queue fills and full rises; bytes
//   that produce no result are still refused while full is high.
//   Reset empties the queue and puts the parser back to waiting for the
//   first header byte of a frame. No clearing pass is needed.
// ----------------------------------------------------------------------------
module websocket_frame_parser_top #(
  parameter int Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [3:0]  opcode_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] frame_length_o,
  output logic        last_o
);
  import wsfp_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  result_t head;

  assign take = push && !full;

  wsfp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  wsfp_queue #(
    .Depth(Depth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_valid),
    .wdata_i(res),
    .rd_i   (pop),
    .rdata_o(head),
    .full_o (full),
    .empty_o(empty)
  );

  assign status_o       = head.status;
  assign opcode_o       = head.opcode;
  assign payload_byte_o = head.payload_byte;
  assign frame_length_o = head.frame_length;
  assign last_o         = head.last;

endmodule
